@@ hdl/bitplane_sprite_xor_draw_defines.svh @@
// Assertion macros shared by the checker
`ifndef BITPLANE_SPRITE_XOR_DRAW_DEFINES_SVH
`define BITPLANE_SPRITE_XOR_DRAW_DEFINES_SVH
// implication checked every clock, quiet during reset
`define BSX_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define BSX_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("check failed");
`endif

@@ hdl/bsx_pkg.sv @@
// ----------------------------------------------------------------------------
// bsx_pkg
// Shared types and command codes of the bit-plane sprite display engine.
// ----------------------------------------------------------------------------
`default_nettype none
package bsx_pkg;

  localparam logic [3:0] KIND_LORES  = 4'd0;
  localparam logic [3:0] KIND_HIRES  = 4'd1;
  localparam logic [3:0] KIND_CLEAR  = 4'd2;
  localparam logic [3:0] KIND_SDOWN  = 4'd3;
  localparam logic [3:0] KIND_SUP    = 4'd4;
  localparam logic [3:0] KIND_SLEFT  = 4'd5;
  localparam logic [3:0] KIND_SRIGHT = 4'd6;
  localparam logic [3:0] KIND_DRAW   = 4'd7;
  localparam logic [3:0] KIND_BYTE   = 4'd8;
  localparam logic [3:0] KIND_READ   = 4'd9;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] plane_mask;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] rows;
    logic [7:0] sprite_byte;
  } bsx_cmd_t;

  typedef struct packed {
    logic       collision;
    logic       done_res;
    logic [3:0] pixel_color;
  } bsx_res_t;

endpackage
`default_nettype wire

@@ hdl/bitplane_sprite_xor_draw.sv @@
// Read visits every plane; clear and scrolls visit each row of every selected
// plane; a mode switch clears every row of every plane.
// Commands are taken one at a time: a new one is accepted only in idle,
// after the previous one has given its result strobe.
// After reset a clearing pass writes zero to every row of every plane
// with busy high; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
// bitplane_sprite_xor_draw
// Four-plane display engine: clears, scrolls, sprite XOR draw, pixel read,
// all through one row memory and a shared row update unit.
// ----------------------------------------------------------------------------
`default_nettype none
module bitplane_sprite_xor_draw
  import bsx_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int PLANE_COUNT   = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bsx_cmd_t cmd_i,
  output bsx_res_t      res_o,
  output logic          res_strobe_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_data_i
);
  localparam int W   = SCREEN_WIDTH;
  localparam int H   = SCREEN_HEIGHT;
  localparam int YW  = $clog2(H);
  localparam int XW  = $clog2(W);
  localparam int PW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int AW  = PW + YW;
  localparam int DEP = PLANE_COUNT * H;
  localparam logic [PLANE_COUNT-1:0] PMASK = '1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_WAIT, S_WR, S_COPY_RD, S_COPY_WAIT, S_COPY_WR,
    S_READ_RD, S_READ_WAIT, S_RESP
  } state_e;

  state_e           state_q;
  logic             wrap_q, hires_q, tall_q, right_q, stop_q, coll_q, done_q;
  logic [PLANE_COUNT-1:0] dplanes_q, mask_q;
  logic [PW-1:0]    plane_q, rplane_q;
  logic [5:0]       left_q, pbytes_q;
  logic [XW-1:0]    sx_q;
  logic [YW-1:0]    sy_q, row_q, scan_q, n_q;
  logic [XW-1:0]    rx_q;
  logic [3:0]       kind_q;
  logic [7:0]       data_q;
  logic [3:0]       color_q;
  logic [AW:0]      init_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [W-1:0]     wdata, rdata;

  bsx_row_ram #(.Width(W), .Depth(1 << AW)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // current geometry
  logic [XW-1:0] wmask;
  logic [YW-1:0] hmask, hlast;
  assign wmask = hires_q ? XW'(W - 1) : XW'(W / 2 - 1);
  assign hmask = hires_q ? YW'(H - 1) : YW'(H / 2 - 1);
  assign hlast = hmask;

  function automatic logic [AW-1:0] addr(logic [PW-1:0] p, logic [YW-1:0] y);
    return {p, y};
  endfunction

  // lowest selected plane after the current one
  logic             np_found;
  logic [PW-1:0]    np_plane;
  logic [PW:0]      np_from;
  always_comb begin
    np_found = 1'b0;
    np_plane = '0;
    for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
      if (dplanes_q[i] && (PW + 1)'(i) >= np_from) begin
        np_found = 1'b1;
        np_plane = PW'(i);
      end
    end
  end
  assign np_from = (PW + 1)'(plane_q) + 1'b1;

  // plane walk for mode switch, clear and scroll
  logic             mp_found;
  logic [PW-1:0]    mp_plane;
  always_comb begin
    mp_found = 1'b0;
    mp_plane = '0;
    for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
      if (mask_q[i] && (PW + 1)'(i) > (PW + 1)'(plane_q)) begin
        mp_found = 1'b1;
        mp_plane = PW'(i);
      end
    end
  end
  logic             fp_found;
  logic [PW-1:0]    fp_plane;
  always_comb begin
    fp_found = 1'b0;
    fp_plane = '0;
    for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
      if (cmd_i.plane_mask[i]) begin
        fp_found = 1'b1;
        fp_plane = PW'(i);
      end
    end
  end

  // vertical scroll: destination and source of the current step
  logic          down;
  logic [YW-1:0] dst_y, src_y;
  logic          src_ok;
  assign down  = (kind_q == KIND_SDOWN);
  assign dst_y = down ? (hlast - scan_q) : scan_q;
  assign src_y = down ? (dst_y - n_q) : (dst_y + n_q);
  assign src_ok = down ? (dst_y >= n_q) : ({1'b0, dst_y} + {1'b0, n_q} <= {1'b0, hlast});

  // sprite byte XOR into the row, shared row update unit
  logic [W-1:0] xmask, newrow, rowmask;
  logic [XW:0]  bx;
  logic         hit;
  always_comb begin
    xmask = '0;
    for (int b = 0; b < 8; b++) begin
      bx = (XW + 1)'(sx_q) + (right_q ? (XW + 1)'(8) : '0) + (XW + 1)'(b);
      if (data_q[7 - b]) begin
        if (wrap_q) xmask[XW'(bx) & wmask] = 1'b1;
        else if (bx <= {1'b0, wmask}) xmask[XW'(bx)] = 1'b1;
      end
    end
  end
  always_comb begin
    rowmask = '0;
    for (int i = 0; i < W; i++) rowmask[i] = (XW'(i) <= wmask) && (i < W);
  end
  assign hit = |(rdata & xmask);

  always_comb begin
    case (kind_q)
      KIND_BYTE:   newrow = rdata ^ xmask;
      KIND_SLEFT:  newrow = (rdata >> 4) & rowmask;
      KIND_SRIGHT: newrow = (rdata << 4) & rowmask;
      KIND_SDOWN, KIND_SUP: newrow = src_ok ? rdata : '0;
      default:     newrow = '0;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = addr(plane_q, row_q);
    wdata = newrow;
    raddr = addr(plane_q, row_q);
    unique case (state_q)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_q[AW-1:0];
        wdata = '0;
      end
      S_WR: begin
        we = !((kind_q == KIND_BYTE) && stop_q);
        waddr = addr(plane_q, row_q);
        wdata = (kind_q == KIND_LORES || kind_q == KIND_HIRES || kind_q == KIND_CLEAR)
                ? '0 : newrow;
      end
      // source row address held until the data is used
      S_COPY_RD, S_COPY_WAIT: raddr = addr(plane_q, src_y);
      S_COPY_WR: begin
        we    = 1'b1;
        waddr = addr(plane_q, dst_y);
      end
      S_READ_RD: raddr = addr(rplane_q, row_q);
      default: ;
    endcase
  end

  assign busy         = (state_q != S_IDLE);
  assign cfg_ready_o  = (state_q == S_IDLE) && !start;
  assign res_strobe_o = (state_q == S_RESP);
  assign res_o        = '{collision: coll_q, done_res: done_q, pixel_color: color_q};

  logic [PLANE_COUNT-1:0] cmask;
  assign cmask = cmd_i.plane_mask & PMASK[PLANE_COUNT-1:0];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; init_q <= '0; wrap_q <= 1'b1; hires_q <= 1'b0;
      tall_q <= 1'b0; right_q <= 1'b0; stop_q <= 1'b0; coll_q <= 1'b0;
      done_q <= 1'b0; dplanes_q <= '0; mask_q <= '0; plane_q <= '0;
      rplane_q <= '0; left_q <= '0; pbytes_q <= '0; sx_q <= '0; sy_q <= '0;
      row_q <= '0; scan_q <= '0; n_q <= '0; rx_q <= '0; kind_q <= '0;
      data_q <= '0; color_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) wrap_q <= cfg_data_i;
      unique case (state_q)
        S_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == (AW + 1)'(DEP - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (start) begin
          kind_q  <= cmd_i.kind;
          data_q  <= cmd_i.sprite_byte;
          done_q  <= 1'b1;
          color_q <= '0;
          mask_q  <= cmask;
          n_q     <= YW'(cmd_i.rows);
          scan_q  <= '0;
          row_q   <= '0;
          if (cmd_i.kind <= KIND_DRAW || cmd_i.kind == KIND_READ) left_q <= '0;
          unique case (cmd_i.kind)
            KIND_LORES, KIND_HIRES: begin
              hires_q <= cmd_i.kind[0];
              mask_q  <= PMASK;
              plane_q <= '0;
              state_q <= S_WR;
            end
            KIND_CLEAR, KIND_SLEFT, KIND_SRIGHT, KIND_SDOWN, KIND_SUP: begin
              plane_q <= fp_plane;
              if (!fp_found || (cmd_i.kind inside {KIND_SDOWN, KIND_SUP}
                                && cmd_i.rows == 4'd0)) state_q <= S_RESP;
              else if (cmd_i.kind inside {KIND_SDOWN, KIND_SUP})
                state_q <= S_COPY_RD;
              else if (cmd_i.kind == KIND_CLEAR) state_q <= S_WR;
              else state_q <= S_RD;
            end
            KIND_DRAW: begin
              coll_q    <= 1'b0;
              sx_q      <= cmd_i.x_pos[XW-1:0] & wmask;
              sy_q      <= cmd_i.y_pos[YW-1:0] & hmask;
              row_q     <= cmd_i.y_pos[YW-1:0] & hmask;
              tall_q    <= (cmd_i.rows == 4'd0);
              pbytes_q  <= (cmd_i.rows == 4'd0) ? 6'd32 : {2'b00, cmd_i.rows};
              dplanes_q <= cmask;
              right_q   <= 1'b0;
              stop_q    <= 1'b0;
              plane_q   <= fp_plane;
              if (fp_found) begin
                left_q <= (cmd_i.rows == 4'd0) ? 6'd32 : {2'b00, cmd_i.rows};
                done_q <= 1'b0;
              end
              state_q <= S_RESP;
            end
            KIND_BYTE: begin
              done_q <= 1'b0;
              row_q  <= row_q;
              state_q <= (left_q == '0) ? S_RESP : S_RD;
            end
            KIND_READ: begin
              rx_q     <= cmd_i.x_pos[XW-1:0] & wmask;
              row_q    <= cmd_i.y_pos[YW-1:0] & hmask;
              rplane_q <= '0;
              state_q  <= S_READ_RD;
            end
            default: begin
              done_q  <= 1'b0;
              state_q <= S_RESP;
            end
          endcase
          if (cmd_i.kind == KIND_BYTE) row_q <= row_q;
        end
        S_RD:   state_q <= S_WAIT;
        S_WAIT: state_q <= S_WR;
        S_WR: begin
          if (kind_q == KIND_BYTE) begin
            if (!stop_q && hit) coll_q <= 1'b1;
            if (tall_q && !right_q) right_q <= 1'b1;
            else begin
              right_q <= 1'b0;
              if (!wrap_q && row_q == hlast) stop_q <= 1'b1;
              else row_q <= (row_q + 1'b1) & hmask;
            end
            left_q <= left_q - 1'b1;
            if (left_q == 6'd1) begin
              if (np_found) begin
                plane_q <= np_plane; left_q <= pbytes_q; row_q <= sy_q;
                right_q <= 1'b0; stop_q <= 1'b0;
              end else done_q <= 1'b1;
            end
            state_q <= S_RESP;
          end else begin
            // whole-row walk for mode switch, clear and horizontal scroll
            if (row_q == hlast || kind_q == KIND_LORES || kind_q == KIND_HIRES) begin
              if (kind_q == KIND_LORES || kind_q == KIND_HIRES) begin
                if (row_q == YW'(H - 1)) begin
                  row_q <= '0;
                  if (mp_found) begin plane_q <= mp_plane; state_q <= S_WR; end
                  else state_q <= S_RESP;
                end else begin
                  row_q <= row_q + 1'b1; state_q <= S_WR;
                end
              end else begin
                row_q <= '0;
                if (mp_found) begin
                  plane_q <= mp_plane;
                  state_q <= (kind_q == KIND_CLEAR) ? S_WR : S_RD;
                end else state_q <= S_RESP;
              end
            end else begin
              row_q <= row_q + 1'b1;
              state_q <= (kind_q == KIND_CLEAR) ? S_WR : S_RD;
            end
          end
        end
        S_COPY_RD:   state_q <= S_COPY_WAIT;
        S_COPY_WAIT: state_q <= S_COPY_WR;
        S_COPY_WR: begin
          if (scan_q == hlast) begin
            scan_q <= '0;
            if (mp_found) begin plane_q <= mp_plane; state_q <= S_COPY_RD; end
            else state_q <= S_RESP;
          end else begin
            scan_q <= scan_q + 1'b1; state_q <= S_COPY_RD;
          end
        end
        S_READ_RD:   state_q <= S_READ_WAIT;
        S_READ_WAIT: begin
          color_q[rplane_q] <= rdata[rx_q];
          if (rplane_q == PW'(PLANE_COUNT - 1)) state_q <= S_RESP;
          else begin rplane_q <= rplane_q + 1'b1; state_q <= S_READ_RD; end
        end
        S_RESP: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/bsx_row_ram.sv @@
// ----------------------------------------------------------------------------
// bsx_row_ram
// Row store of all planes: one row word per address, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bsx_row_ram #(
  parameter int Width = 128,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // single write, single registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/bsx_checker.sv @@
// ----------------------------------------------------------------------------
// bsx_checker
// Port-level checks of the display engine's command handshake.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitplane_sprite_xor_draw_defines.svh"
module bsx_checker
  import bsx_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire bsx_res_t res_o,
  input wire logic     res_strobe_o,
  input wire logic     cfg_ready_o
);
  // accepted command keeps the block busy
  `BSX_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, start && !busy, busy)
  // result strobe lasts one cycle
  `BSX_ASSERT_NXT(a_strobe_one, clk_i, rst_ni, res_strobe_o, !res_strobe_o)
  // result only while busy, then idle
  `BSX_ASSERT_NXT(a_strobe_idle, clk_i, rst_ni, res_strobe_o, !busy)
  // no config write while busy
  `BSX_ASSERT_IMP(a_cfg_idle, clk_i, rst_ni, busy, !cfg_ready_o)
  // colour only from a read
  `BSX_ASSERT_IMP(a_color, clk_i, rst_ni, res_strobe_o && !res_o.done_res,
                  res_o.pixel_color == 4'd0)
endmodule

bind bitplane_sprite_xor_draw bsx_checker u_bsx_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .res_o(res_o), .res_strobe_o(res_strobe_o), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire
